/* design/minv_pkg.sv */
`timescale 1ns / 1ps
package minv_pkg;

  localparam int NUM_ELEM = 9;
  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = 16;
  localparam int THR_FRAC = 32;
  localparam int THR_W    = 20;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic FUNC_INV3 = 1'b0;
  localparam logic FUNC_INV2 = 1'b1;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] THR_RESET = 20'd4295;

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // Cofactor i = e[CA]*e[CB] - e[CC]*e[CD]
  localparam int CA [NUM_ELEM] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int CB [NUM_ELEM] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int CC [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 3};
  localparam int CD [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 1};

  // Queue status seen by the back end
  typedef struct packed {
    logic avail;
    logic is2;
  } minv_q_t;

endpackage

/* design/minv_front.sv */
`timescale 1ns / 1ps
module minv_front import minv_pkg::*; #(
  parameter int W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                func,
  input  logic signed [W-1:0] a_in [NUM_ELEM],
  output logic                busy,
  input  logic                pop,
  output minv_q_t             status,
  output logic signed [W-1:0] elem [NUM_ELEM]
);

  logic [1:0]          count;
  logic                wptr;
  logic                rptr;
  logic                is2_mem [2];
  logic signed [W-1:0] emem [2][NUM_ELEM];
  logic                push;
  logic                is2_in;
  logic signed [W-1:0] cls [NUM_ELEM];

  assign busy   = (count == 2'd2);
  assign push   = start && !busy;
  assign is2_in = (func == FUNC_INV2);

  // Drop the elements a 2x2 item does not use
  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      cls[i] = a_in[i];
    end
    if (is2_in) begin
      cls[2] = '0;
      cls[5] = '0;
      cls[6] = '0;
      cls[7] = '0;
      cls[8] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      emem[wptr]    <= cls;
      is2_mem[wptr] <= is2_in;
    end
  end

  assign status.avail = (count != 2'd0);
  assign status.is2   = is2_mem[rptr];
  assign elem         = emem[rptr];

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a push");

endmodule

/* design/minv_div.sv */
`timescale 1ns / 1ps
module minv_div import minv_pkg::*; #(
  parameter int MW = 72,
  parameter int HW = 48
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [HW-1:0]    n_hi,
  input  logic [OUT_W-1:0] n_lo,
  input  logic [MW-1:0]    d,
  input  logic             neg,
  output logic [OUT_W-1:0] res
);

  localparam int CW = ((HW > MW) ? HW : MW) + 1;

  logic [MW-1:0]    rem;
  logic [OUT_W-1:0] lo;
  logic [OUT_W-1:0] q;
  logic             ovf;
  logic             sgn;
  logic [MW:0]      shifted;
  logic             fits;
  logic             rnd;
  logic [OUT_W:0]   qr;
  logic             big;

  assign shifted = {rem, lo[OUT_W-1]};
  assign fits    = shifted >= {1'b0, d};

  // One quotient bit per step, restoring
  always_ff @(posedge clk) begin
    if (load) begin
      ovf <= CW'(n_hi) >= CW'(d);
      rem <= MW'(n_hi);
      lo  <= n_lo;
      q   <= '0;
      sgn <= neg;
    end else if (step) begin
      rem <= fits ? MW'(shifted - {1'b0, d}) : MW'(shifted);
      lo  <= {lo[OUT_W-2:0], 1'b0};
      q   <= {q[OUT_W-2:0], fits};
    end
  end

  assign rnd = {rem, 1'b0} >= {1'b0, d};
  assign qr  = {1'b0, q} + (OUT_W+1)'(rnd);
  assign big = qr[OUT_W] | qr[OUT_W-1];

  always_comb begin
    if (ovf || big) begin
      res = sgn ? SAT_NEG : SAT_POS;
    end else if (sgn) begin
      res = -qr[OUT_W-1:0];
    end else begin
      res = qr[OUT_W-1:0];
    end
  end

endmodule

/* design/minv_back.sv */
`timescale 1ns / 1ps
module minv_back import minv_pkg::*; #(
  parameter int W = 24,
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  minv_q_t                 status,
  input  logic signed [W-1:0]     elem [NUM_ELEM],
  input  logic [THR_W-1:0]        thr,
  output logic                    pop,
  output logic                    done,
  output logic signed [OUT_W-1:0] b [NUM_ELEM],
  output logic signed [OUT_W-1:0] det_value,
  output logic                    singular
);

  localparam int PW    = 2 * W;
  localparam int JW    = 2 * W + 1;
  localparam int DW    = 3 * W + 1;
  localparam int MW    = 3 * W;
  localparam int AW    = 2 * W;
  localparam int NW    = AW + F + OUT_FRAC;
  localparam int HW    = NW - OUT_W;
  localparam int CNT_W = $clog2(OUT_W);
  localparam int DF2   = 2 * F;
  localparam int DF3   = 3 * F;
  localparam int L2    = (DF2 < THR_FRAC) ? THR_FRAC - DF2 : 0;
  localparam int R2    = (DF2 > THR_FRAC) ? DF2 - THR_FRAC : 0;
  localparam int L3    = (DF3 < THR_FRAC) ? THR_FRAC - DF3 : 0;
  localparam int R3    = (DF3 > THR_FRAC) ? DF3 - THR_FRAC : 0;
  localparam int CMPW  = MW + THR_FRAC + THR_W;
  localparam int S2    = DF2 - OUT_FRAC;
  localparam int S3    = DF3 - OUT_FRAC;
  localparam logic [MW:0] H2 = ((MW+1)'(1) << S2) >> 1;
  localparam logic [MW:0] H3 = ((MW+1)'(1) << S3) >> 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_COF, ST_DMUL, ST_DET, ST_ABS, ST_CHK, ST_DIV, ST_FIN
  } state_t;

  state_t               state;
  logic                 is2;
  logic signed [W-1:0]  e [NUM_ELEM];
  logic signed [PW-1:0] p [2*NUM_ELEM];
  logic signed [PW-1:0] p_next [2*NUM_ELEM];
  logic signed [JW-1:0] cof [NUM_ELEM];
  logic signed [JW-1:0] cof_next [NUM_ELEM];
  logic signed [JW-1:0] th [3];
  logic signed [JW-1:0] tl [3];
  logic signed [JW-1:0] th_next [3];
  logic signed [JW-1:0] tl_next [3];
  logic signed [DW-1:0] det;
  logic signed [DW-1:0] det_next;
  logic signed [JW-1:0] adj [NUM_ELEM];
  logic signed [JW-1:0] adj_next [NUM_ELEM];
  logic [MW-1:0]        mdet;
  logic                 dneg;
  logic [AW-1:0]        amag [NUM_ELEM];
  logic                 aneg [NUM_ELEM];
  logic                 sing_r;
  logic                 sing_next;
  logic [OUT_W-1:0]     dv_r;
  logic [OUT_W-1:0]     dv_next;
  logic [CNT_W-1:0]     cnt;
  logic [CMPW-1:0]      lhs;
  logic [CMPW-1:0]      rhs;
  logic [MW:0]          dvm;
  logic [NW-1:0]        num [NUM_ELEM];
  logic [OUT_W-1:0]     lane_res [NUM_ELEM];

  assign pop = (state == ST_IDLE) && status.avail;

  // Two products per cofactor
  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      p_next[2*i]   = e[CA[i]] * e[CB[i]];
      p_next[2*i+1] = e[CC[i]] * e[CD[i]];
      cof_next[i]   = JW'(p[2*i]) - JW'(p[2*i+1]);
    end
  end

  // Row-0 expansion, each cofactor split into high and low halves
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      th_next[k] = $signed(cof[3*k][JW-1:W]) * e[k];
      tl_next[k] = $signed({1'b0, cof[3*k][W-1:0]}) * e[k];
    end
  end

  always_comb begin
    det_next = '0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      adj_next[i] = '0;
    end
    if (is2) begin
      det_next    = DW'(cof[8]);
      adj_next[0] = JW'(e[4]);
      adj_next[1] = -JW'(e[1]);
      adj_next[3] = -JW'(e[3]);
      adj_next[4] = JW'(e[0]);
    end else begin
      for (int k = 0; k < 3; k++) begin
        det_next = det_next + $signed({th[k], {W{1'b0}}}) + DW'(tl[k]);
      end
      for (int i = 0; i < NUM_ELEM; i++) begin
        adj_next[i] = cof[i];
      end
    end
  end

  // Threshold compare and rounded determinant
  always_comb begin
    lhs       = is2 ? (CMPW'(mdet) << L2) : (CMPW'(mdet) << L3);
    rhs       = is2 ? (CMPW'(thr) << R2) : (CMPW'(thr) << R3);
    sing_next = (mdet == '0) || (lhs < rhs);
    dvm       = is2 ? (({1'b0, mdet} + H2) >> S2) : (({1'b0, mdet} + H3) >> S3);
    if (|dvm[MW:OUT_W-1]) begin
      dv_next = dneg ? SAT_NEG : SAT_POS;
    end else if (dneg) begin
      dv_next = -dvm[OUT_W-1:0];
    end else begin
      dv_next = dvm[OUT_W-1:0];
    end
  end

  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
    assign num[i] = {amag[i], {(F+OUT_FRAC){1'b0}}};
    minv_div #(
      .MW (MW),
      .HW (HW)
    ) u_div (
      .clk  (clk),
      .load (state == ST_CHK),
      .step (state == ST_DIV),
      .n_hi (num[i][NW-1:OUT_W]),
      .n_lo (num[i][OUT_W-1:0]),
      .d    (mdet),
      .neg  (aneg[i] ^ dneg),
      .res  (lane_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (status.avail) begin
            e     <= elem;
            is2   <= status.is2;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          p     <= p_next;
          state <= ST_COF;
        end
        ST_COF: begin
          cof   <= cof_next;
          state <= ST_DMUL;
        end
        ST_DMUL: begin
          th    <= th_next;
          tl    <= tl_next;
          state <= ST_DET;
        end
        ST_DET: begin
          det   <= det_next;
          adj   <= adj_next;
          state <= ST_ABS;
        end
        ST_ABS: begin
          mdet <= MW'(det[DW-1] ? -det : det);
          dneg <= det[DW-1];
          for (int i = 0; i < NUM_ELEM; i++) begin
            amag[i] <= AW'(adj[i][JW-1] ? -adj[i] : adj[i]);
            aneg[i] <= adj[i][JW-1];
          end
          state <= ST_CHK;
        end
        ST_CHK: begin
          sing_r <= sing_next;
          dv_r   <= dv_next;
          cnt    <= CNT_W'(OUT_W - 1);
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < NUM_ELEM; i++) begin
            b[i] <= sing_r ? '0 : lane_res[i];
          end
          det_value <= dv_r;
          singular  <= sing_r;
          done      <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two results back to back");
  assert property (@(posedge clk) disable iff (rst) (done && singular) |->
    (b[0] == 0 && b[1] == 0 && b[2] == 0 && b[3] == 0 && b[4] == 0 &&
     b[5] == 0 && b[6] == 0 && b[7] == 0 && b[8] == 0))
    else $error("singular item with nonzero inverse");
  assert property (@(posedge clk) disable iff (rst) (done && is2) |->
    (b[2] == 0 && b[5] == 0 && b[6] == 0 && b[7] == 0 && b[8] == 0))
    else $error("2x2 item with nonzero outer elements");

endmodule

/* design/matrix_inverse_3x3_2x2.sv */
`timescale 1ns / 1ps
// Channel  | Ports                              | Handshake
// ---------+------------------------------------+-----------------------------------
// item in  | func, a00..a22                     | taken when start high, busy low
// item out | b00..b22, det_value, singular      | done high one cycle, no stall
// config   | psel penable pwrite paddr pwdata   | APB, pready tied high
//
// An item passes from the queue through product, cofactor, determinant and
//   magnitude states, one check state, 32 steps of the nine restoring divider
//   lanes (one quotient bit each per cycle) and one output state.
// A two-entry queue sits in front; busy rises only while it is full.
// Reset (rst, synchronous) empties the queue, idles the sequencer and loads
//   singular_threshold with 4295.
// Results cannot be held off: each item's values appear with done and stay until the next done.
module matrix_inverse_3x3_2x2 import minv_pkg::*; #(
  parameter int ELEM_WIDTH = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  output logic                         done,
  input  logic                         func,
  input  logic signed [ELEM_WIDTH-1:0] a00,
  input  logic signed [ELEM_WIDTH-1:0] a01,
  input  logic signed [ELEM_WIDTH-1:0] a02,
  input  logic signed [ELEM_WIDTH-1:0] a10,
  input  logic signed [ELEM_WIDTH-1:0] a11,
  input  logic signed [ELEM_WIDTH-1:0] a12,
  input  logic signed [ELEM_WIDTH-1:0] a20,
  input  logic signed [ELEM_WIDTH-1:0] a21,
  input  logic signed [ELEM_WIDTH-1:0] a22,
  output logic signed [OUT_W-1:0]      b00,
  output logic signed [OUT_W-1:0]      b01,
  output logic signed [OUT_W-1:0]      b02,
  output logic signed [OUT_W-1:0]      b10,
  output logic signed [OUT_W-1:0]      b11,
  output logic signed [OUT_W-1:0]      b12,
  output logic signed [OUT_W-1:0]      b20,
  output logic signed [OUT_W-1:0]      b21,
  output logic signed [OUT_W-1:0]      b22,
  output logic signed [OUT_W-1:0]      det_value,
  output logic                         singular,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready
);

  logic [THR_W-1:0]             threshold;
  logic signed [ELEM_WIDTH-1:0] a_in [NUM_ELEM];
  logic signed [ELEM_WIDTH-1:0] elem [NUM_ELEM];
  logic signed [OUT_W-1:0]      b [NUM_ELEM];
  minv_q_t                      status;
  logic                         pop;
  logic                         reg_hit;

  // Register index is the word address; only the threshold exists
  assign reg_hit = (paddr[ADDR_W-1] == REG_THRESHOLD);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? DATA_W'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  assign a_in[0] = a00;
  assign a_in[1] = a01;
  assign a_in[2] = a02;
  assign a_in[3] = a10;
  assign a_in[4] = a11;
  assign a_in[5] = a12;
  assign a_in[6] = a20;
  assign a_in[7] = a21;
  assign a_in[8] = a22;

  // Front: take items, mark 2x2, queue them
  minv_front #(
    .W (ELEM_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .a_in   (a_in),
    .busy   (busy),
    .pop    (pop),
    .status (status),
    .elem   (elem)
  );

  // Back: determinant, adjugate, threshold test and division
  minv_back #(
    .W (ELEM_WIDTH),
    .F (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .elem      (elem),
    .thr       (threshold),
    .pop       (pop),
    .done      (done),
    .b         (b),
    .det_value (det_value),
    .singular  (singular)
  );

  assign b00 = b[0];
  assign b01 = b[1];
  assign b02 = b[2];
  assign b10 = b[3];
  assign b11 = b[4];
  assign b12 = b[5];
  assign b20 = b[6];
  assign b21 = b[7];
  assign b22 = b[8];

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import minv_pkg::*;

  localparam int EW = 24;
  localparam int FB = 16;

  // One inversion result as the block presents it
  typedef struct packed {
    logic [8:0][OUT_W-1:0] inv;
    logic [OUT_W-1:0]      det;
    logic                  sing;
  } inv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic func = FUNC_INV3;
  logic [8:0][EW-1:0] mat = '0;
  logic [OUT_W-1:0] bv [9];
  logic [OUT_W-1:0] det_value;
  logic singular;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic [THR_W-1:0] cur_threshold = THR_RESET;
  inv_result_t expected_q[$];
  int errors = 0;
  int n_items = 0, n_2x2 = 0, n_sing = 0, n_checked = 0;
  bit idle_on = 1'b1;

  always #4 clk = ~clk;

  matrix_inverse_3x3_2x2 i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .func(func),
    .a00(mat[0]), .a01(mat[1]), .a02(mat[2]), .a10(mat[3]), .a11(mat[4]),
    .a12(mat[5]), .a20(mat[6]), .a21(mat[7]), .a22(mat[8]),
    .b00(bv[0]), .b01(bv[1]), .b02(bv[2]), .b10(bv[3]), .b11(bv[4]), .b12(bv[5]),
    .b20(bv[6]), .b21(bv[7]), .b22(bv[8]), .det_value(det_value), .singular(singular),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  function automatic logic [OUT_W-1:0] sat_q16(bit neg, logic [127:0] mag);
    if (!neg) return (mag > 128'h7FFF_FFFF) ? SAT_POS : mag[OUT_W-1:0];
    if (mag >= 128'h8000_0000) return SAT_NEG;
    return -mag[OUT_W-1:0];
  endfunction

  // Exact wide-integer inverse: adjugate over determinant, round half up on
  // magnitudes, saturate to Q16.16
  function automatic inv_result_t compute_inverse(logic is2, logic [8:0][EW-1:0] m,
                                                  logic [THR_W-1:0] thr);
    logic signed [127:0] el [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] det;
    logic [127:0] mdet, num, q, r, rnd;
    int dshift;
    inv_result_t res;
    for (int i = 0; i < 9; i++) begin
      el[i] = $signed(m[i]);
      adj[i] = '0;
    end
    if (is2 == FUNC_INV3) begin
      adj[0] = el[4]*el[8] - el[5]*el[7];
      adj[1] = el[2]*el[7] - el[1]*el[8];
      adj[2] = el[1]*el[5] - el[2]*el[4];
      adj[3] = el[5]*el[6] - el[3]*el[8];
      adj[4] = el[0]*el[8] - el[2]*el[6];
      adj[5] = el[3]*el[2] - el[0]*el[5];
      adj[6] = el[3]*el[7] - el[4]*el[6];
      adj[7] = el[6]*el[1] - el[0]*el[7];
      adj[8] = el[0]*el[4] - el[3]*el[1];
      det = adj[0]*el[0] + adj[3]*el[1] + adj[6]*el[2];
      dshift = 3*FB - OUT_FRAC;
    end else begin
      det = el[0]*el[4] - el[1]*el[3];
      adj[0] = el[4];
      adj[1] = -el[1];
      adj[3] = -el[3];
      adj[4] = el[0];
      dshift = 2*FB - OUT_FRAC;
    end
    mdet = det[127] ? -det : det;
    // 3x3 determinant carries 48 fraction bits, threshold 32
    if (is2 == FUNC_INV3) res.sing = (mdet == 0) || (mdet < ({108'd0, thr} << 16));
    else res.sing = (mdet == 0) || (mdet < {108'd0, thr});
    for (int i = 0; i < 9; i++) begin
      if (res.sing) begin
        res.inv[i] = '0;
      end else begin
        num = (adj[i][127] ? -adj[i] : adj[i]) << (FB + OUT_FRAC);
        q = num / mdet;
        r = num % mdet;
        if ((r << 1) >= mdet) q = q + 1;
        res.inv[i] = sat_q16(adj[i][127] != det[127], q);
      end
    end
    rnd = (mdet + (128'd1 << (dshift - 1))) >> dshift;
    res.det = sat_q16(det[127], rnd);
    return res;
  endfunction

  // Check every done cycle against the oldest prediction
  always @(posedge clk) begin
    inv_result_t want;
    string nm;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        for (int i = 0; i < 9; i++) begin
          if (bv[i] !== want.inv[i]) begin
            nm = $sformatf("b%0d%0d", i / 3, i % 3);
            $error("%s expected %h actual %h", nm, want.inv[i], bv[i]);
            errors++;
          end
        end
        if (det_value !== want.det) begin
          $error("det_value expected %h actual %h", want.det, det_value);
          errors++;
        end
        if (singular !== want.sing) begin
          $error("singular expected %b actual %b", want.sing, singular);
          errors++;
        end
      end
    end
  end

  // Present one item and hold it until taken; start stays high afterwards except for random idle gaps
  task automatic send_matrix(logic is2, logic [8:0][EW-1:0] m);
    inv_result_t res;
    func <= is2;
    mat <= m;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    res = compute_inverse(is2, m, cur_threshold);
    expected_q.push_back(res);
    n_items++;
    if (is2 == FUNC_INV2) n_2x2++;
    if (res.sing) n_sing++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drop start and let the pipeline empty before touching the register
  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if ((addr >> 2) == REG_THRESHOLD) cur_threshold = data[THR_W-1:0];
    @(posedge clk);
  endtask

  task automatic reg_read_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[THR_W-1:0] !== cur_threshold) begin
      $error("singular_threshold expected %h actual %h", cur_threshold, prdata[THR_W-1:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [EW-1:0] rand_elem();
    case ($urandom_range(0, 4))
      0, 1: return EW'($urandom());
      2: return EW'($urandom_range(0, 1 << 18) - (1 << 17));
      3: return EW'($urandom_range(0, 1 << 20) - (1 << 19));
      default: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return {1'b0, {(EW-1){1'b1}}};
          2: return {1'b1, {(EW-1){1'b0}}};
          3: return 24'h010000;
          default: return 24'hFF0000;
        endcase
      end
    endcase
  endfunction

  // Mostly well-conditioned content, some rank-deficient rows
  task automatic send_random_matrix();
    logic [8:0][EW-1:0] m;
    logic is2;
    for (int i = 0; i < 9; i++) m[i] = rand_elem();
    is2 = $urandom_range(0, 2) == 0;
    case ($urandom_range(0, 7))
      0: begin
        // copy a row, add a tiny perturbation: nearly singular
        for (int j = 0; j < 3; j++) m[3 + j] = EW'(m[j] + $urandom_range(0, 3));
      end
      1: begin
        for (int j = 0; j < 3; j++) m[6 + j] = m[j];
      end
      default: ;
    endcase
    send_matrix(is2, m);
  endtask

  task automatic test_directed();
    logic [8:0][EW-1:0] m;
    logic [EW-1:0] one, mx, mn;
    one = 24'h010000;
    mx = {1'b0, {(EW-1){1'b1}}};
    mn = {1'b1, {(EW-1){1'b0}}};
    // identity, both sizes
    m = '0; m[0] = one; m[4] = one; m[8] = one;
    send_matrix(FUNC_INV3, m);
    send_matrix(FUNC_INV2, m);
    // zero matrix: zero determinant
    send_matrix(FUNC_INV3, '0);
    send_matrix(FUNC_INV2, '0);
    // all max, all min elements
    for (int i = 0; i < 9; i++) m[i] = mx;
    send_matrix(FUNC_INV3, m);
    send_matrix(FUNC_INV2, m);
    for (int i = 0; i < 9; i++) m[i] = mn;
    send_matrix(FUNC_INV3, m);
    // diagonal of extremes: determinant saturates both ways
    m = '0; m[0] = mx; m[4] = mx; m[8] = mx;
    send_matrix(FUNC_INV3, m);
    m[0] = mn;
    send_matrix(FUNC_INV3, m);
    send_matrix(FUNC_INV2, m);
    // tiny diagonal: inverse saturates unless flagged singular
    m = '0; m[0] = 24'd2; m[4] = 24'd3; m[8] = 24'hFFFFFE;
    send_matrix(FUNC_INV3, m);
    m = '0; m[0] = 24'd70; m[4] = 24'hFFFFC0;
    send_matrix(FUNC_INV2, m);
    m[0] = 24'd1; m[4] = 24'd1;
    send_matrix(FUNC_INV2, m);
    // anti-diagonal with upper rows only used by 2x2, garbage below
    m = '0; m[1] = one; m[3] = mn; m[5] = mx; m[6] = 24'h123456; m[8] = mx;
    send_matrix(FUNC_INV2, m);
    send_matrix(FUNC_INV3, m);
    // mixed signs, exact rational inverse
    m = '0; m[0] = 24'h020000; m[1] = 24'hFF0000; m[3] = 24'h010000;
    m[4] = 24'h030000; m[8] = 24'h008000;
    send_matrix(FUNC_INV3, m);
    send_matrix(FUNC_INV2, m);
    drain();
  endtask

  task automatic test_threshold_extremes();
    logic [8:0][EW-1:0] m;
    reg_read_check();
    // threshold zero: only a zero determinant is singular
    reg_write(3'd0, 32'h0);
    reg_read_check();
    send_matrix(FUNC_INV3, '0);
    m = '0; m[0] = 24'd1; m[4] = 24'd1;
    send_matrix(FUNC_INV2, m);
    m[8] = 24'd1;
    send_matrix(FUNC_INV3, m);
    drain();
    // writes to the unmapped index leave the register alone
    reg_write(3'd4, 32'hFFFF_FFFF);
    reg_read_check();
    // largest threshold, upper data bits ignored
    reg_write(3'd0, 32'hFFFF_FFFF);
    reg_read_check();
    m = '0; m[0] = 24'h000400; m[4] = 24'h000400;
    send_matrix(FUNC_INV2, m);
    m[0] = 24'h000FFF; m[4] = 24'h000101;
    send_matrix(FUNC_INV2, m);
    m = '0; m[0] = 24'h010000; m[4] = 24'h010000; m[8] = 24'h010000;
    send_matrix(FUNC_INV3, m);
    drain();
  endtask

  task automatic test_random(int count, logic [DATA_W-1:0] thr);
    reg_write(3'd0, thr);
    for (int k = 0; k < count; k++) send_random_matrix();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_extremes();
    test_random(400, THR_RESET);
    test_random(300, 32'h0);
    test_random(300, 32'h000F_FFFF);
    test_random(400, $urandom_range(0, 32'hF_FFFF));
    idle_on = 1'b0;
    test_random(500, $urandom_range(0, 32'h1_0000));
    $display("Ran %0d matrices (%0d of them 2x2, %0d singular), %0d results checked",
             n_items, n_2x2, n_sing, n_checked);
    $display("over threshold settings from zero to full scale");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
